// ----- sv/pot_pickup_cv_mixer_defines.svh -----
// assertion helpers for the mixer module
`ifndef POT_PICKUP_CV_MIXER_DEFINES_SVH
`define POT_PICKUP_CV_MIXER_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define PPCM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk outside reset
`define PPCM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/ppcm_pkg.sv -----
`timescale 1ns / 1ps

package ppcm_pkg;

	// converter scale
	localparam int FS_BITS    = 12;
	localparam int FULL_SCALE = (1 << FS_BITS) - 1;
	localparam logic [FS_BITS-1:0] FS_MAX = '1;

	// store geometry
	localparam int NUM_KNOBS   = 3;
	localparam int NUM_PRESETS = 32;
	localparam int STORE_DEPTH = NUM_KNOBS * NUM_PRESETS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	// field widths
	localparam int KIND_W    = 2;
	localparam int PRESET_W  = 5;
	localparam int KNOB_W    = 2;
	localparam int VAL_W     = 8;
	localparam int DEPTH_W   = 7;
	localparam int MODE_W    = 2;
	localparam int CFG_W     = DEPTH_W;
	localparam int CFG_IDX_W = 2;

	// arithmetic widths
	localparam int PROD_W    = FS_BITS + VAL_W;
	localparam int SPROD_W   = PROD_W + 2;
	localparam int SVAL_W    = VAL_W + 3;
	localparam int PCT_W     = FS_BITS + DEPTH_W;
	localparam int MAX_DEPTH = 100;
	localparam int RCP_SHIFT = PCT_W;
	localparam int RCP_MUL   = (1 << RCP_SHIFT) / MAX_DEPTH + 1;
	localparam int RCP_W     = $clog2(RCP_MUL + 1);
	localparam int RCPP_W    = PCT_W + RCP_W;
	localparam logic [RCP_W-1:0] RCP_K = RCP_W'(RCP_MUL);
	localparam logic [DEPTH_W-1:0] DEPTH_CAP = DEPTH_W'(MAX_DEPTH);
	localparam int DIV_CNT_W = $clog2(FS_BITS + 1);

	// item kinds
	localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	// cv modes
	localparam logic [MODE_W-1:0] CV_OFF = 2'd0;
	localparam logic [MODE_W-1:0] CV_UNI = 2'd1;
	localparam logic [MODE_W-1:0] CV_BI  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CV_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CV_TARGET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CV_DEPTH  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_RCP,
		S_COR,
		S_MUL2,
		S_MAP2,
		S_FIN
	} state_t;

	typedef struct packed {
		logic              re;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [VAL_W-1:0]  wdata;
	} ram_req_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [VAL_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [FS_BITS-1:0] quot;
	} div_rsp_t;

	// floor(m / FULL_SCALE) for m below 2**VAL_W * FULL_SCALE
	function automatic logic [VAL_W-1:0] div_fs(input logic [PROD_W-1:0] m);
		logic [PROD_W-1:0] s;
		logic [PROD_W-1:0] r;
		logic [VAL_W-1:0]  q;
		s = m + (m >> FS_BITS);
		q = s[PROD_W-1:FS_BITS];
		r = m - {q, {FS_BITS{1'b0}}} + PROD_W'(q);
		if (r >= PROD_W'(FULL_SCALE)) begin
			q = q + 1'b1;
		end
		return q;
	endfunction

	// x < lo gives lo, then x > hi gives hi
	function automatic logic [VAL_W-1:0] clamp_r(input logic signed [SVAL_W-1:0] x,
			input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi);
		logic signed [SVAL_W-1:0] slo;
		logic signed [SVAL_W-1:0] shi;
		logic [VAL_W-1:0]         res;
		slo = $signed({3'b000, lo});
		shi = $signed({3'b000, hi});
		if (x < slo) begin
			res = lo;
		end else if (x > shi) begin
			res = hi;
		end else begin
			res = x[VAL_W-1:0];
		end
		return res;
	endfunction

	// product of reading and span, divided by full scale toward zero, offset and clamped
	function automatic logic [VAL_W-1:0] to_range(input logic signed [SPROD_W-1:0] prod,
			input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi);
		logic [SPROD_W-1:0]       mag;
		logic [VAL_W-1:0]         q;
		logic signed [SVAL_W-1:0] x;
		mag = prod[SPROD_W-1] ? $unsigned(-prod) : $unsigned(prod);
		q = div_fs(mag[PROD_W-1:0]);
		x = prod[SPROD_W-1] ? -$signed({3'b000, q}) : $signed({3'b000, q});
		x = x + $signed({3'b000, lo});
		return clamp_r(x, lo, hi);
	endfunction

	// reciprocal estimate is exact or one too high
	function automatic logic [FS_BITS-1:0] pct_fix(input logic [FS_BITS-1:0] est,
			input logic [PCT_W-1:0] n);
		logic [PCT_W-1:0]   back;
		logic [FS_BITS-1:0] res;
		back = PCT_W'(est) * PCT_W'(MAX_DEPTH);
		res = (back > n) ? est - 1'b1 : est;
		return res;
	endfunction

endpackage

// ----- sv/ppcm_in_if.sv -----
`timescale 1ns / 1ps

interface ppcm_in_if;
	logic                            valid;
	logic                            ready;
	logic [ppcm_pkg::KIND_W-1:0]     kind;
	logic [ppcm_pkg::PRESET_W-1:0]   preset;
	logic [ppcm_pkg::KNOB_W-1:0]     knob;
	logic [ppcm_pkg::FS_BITS-1:0]    knob_reading;
	logic [ppcm_pkg::FS_BITS-1:0]    cv_reading;
	logic [ppcm_pkg::VAL_W-1:0]      range_low;
	logic [ppcm_pkg::VAL_W-1:0]      range_high;
	logic [ppcm_pkg::VAL_W-1:0]      load_value;

	modport source (
		output valid, kind, preset, knob, knob_reading, cv_reading,
		       range_low, range_high, load_value,
		input  ready
	);

	modport sink (
		input  valid, kind, preset, knob, knob_reading, cv_reading,
		       range_low, range_high, load_value,
		output ready
	);
endinterface

// ----- sv/ppcm_out_if.sv -----
`timescale 1ns / 1ps

interface ppcm_out_if;
	logic                         valid;
	logic                         ready;
	logic [ppcm_pkg::FS_BITS-1:0] drive_level;
	logic [ppcm_pkg::VAL_W-1:0]   param_value;
	logic                         picked_up;

	modport source (
		output valid, drive_level, param_value, picked_up,
		input  ready
	);

	modport sink (
		input  valid, drive_level, param_value, picked_up,
		output ready
	);
endinterface

// ----- sv/pot_pickup_cv_mixer.sv -----
`timescale 1ns / 1ps
// Knob soft-pickup and cv mixer.
// in_ch carries one item per transfer: a knob sample, a stored-value load, or a
// clear of all pickup flags, with the preset row, knob, readings and range.
// out_ch returns exactly one result per item: drive level, stored value of the
// entry after the item, and the knob's pickup flag.
// cfg_we/cfg_index/cfg_data write cv_mode, cv_target_pot and cv_depth; write
// them only while no item is in flight.
// An item runs through the read, reciprocal, correction, multiply, map and
// final steps, and leaves the final step only once the 12-step level divider
// that maps a stored value back to full scale is done; the divider runs beside
// the scaling steps for every item. One item is worked at a time: the stored
// value is read from a single-port memory, modified and written back.
// Reset clears the pickup flags, the cv registers and the control state; the
// stored values are undefined until loaded.
// The result sits in an output register: if out_ch stalls, the block holds the
// finished item in its last step until the register frees, and in_ch ready
// stays low meanwhile.

`include "pot_pickup_cv_mixer_defines.svh"

module pot_pickup_cv_mixer (
	input  logic                           clk,
	input  logic                           arst_n,
	ppcm_in_if.sink                        in_ch,
	ppcm_out_if.source                     out_ch,
	input  logic                           cfg_we,
	input  logic [ppcm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ppcm_pkg::CFG_W-1:0]     cfg_data
);

	ppcm_pkg::state_t state_q, state_d;

	logic in_ready, in_xfer, out_free, fin_go, div_start;

	// configuration
	logic [ppcm_pkg::MODE_W-1:0]  cv_mode_q;
	logic [ppcm_pkg::KNOB_W-1:0]  cv_target_q;
	logic [ppcm_pkg::DEPTH_W-1:0] cv_depth_q;

	// captured item
	logic [ppcm_pkg::KIND_W-1:0]  kind_q;
	logic [ppcm_pkg::KNOB_W-1:0]  knob_q;
	logic [ppcm_pkg::FS_BITS-1:0] rd_q, cvr_q;
	logic [ppcm_pkg::VAL_W-1:0]   lo_q, hi_q, load_q;
	logic [ppcm_pkg::ADDR_W-1:0]  addr_q;
	logic                         valid_q;

	logic [ppcm_pkg::NUM_KNOBS-1:0] flags_q;

	ppcm_pkg::ram_req_t          ram_req;
	logic [ppcm_pkg::VAL_W-1:0]  ram_rdata;
	ppcm_pkg::div_req_t          div_req;
	ppcm_pkg::div_rsp_t          div_rsp;

	logic [ppcm_pkg::ADDR_W-1:0]  in_addr;
	logic                         in_knob_ok;
	logic signed [ppcm_pkg::VAL_W:0] span;
	logic [ppcm_pkg::VAL_W-1:0]   span_mag;
	logic signed [ppcm_pkg::VAL_W:0] num, num_neg;
	logic [ppcm_pkg::VAL_W-1:0]   num_mag;
	logic [ppcm_pkg::DEPTH_W-1:0] depth_sat;
	logic [ppcm_pkg::RCPP_W-1:0]  rcp_c, rcp_h;
	logic [ppcm_pkg::FS_BITS-1:0] h_full;

	// pipeline registers of the scaling steps
	logic signed [ppcm_pkg::SPROD_W-1:0] prod_p_s1, prod_c_s4, prod_h_s4;
	logic [ppcm_pkg::PCT_W-1:0]   pct_c_s1, pct_h_s1;
	logic [ppcm_pkg::VAL_W-1:0]   p8_s2, c8_s5, h8_s5;
	logic [ppcm_pkg::FS_BITS-1:0] est_c_s2, est_h_s2, c_s3;
	logic [ppcm_pkg::FS_BITS-2:0] h_s3;

	// final step
	logic                          hit, flag_cur, flag_new, cv_sel, wr_en;
	logic [ppcm_pkg::FS_BITS:0]    lvl_uni;
	logic signed [ppcm_pkg::FS_BITS+1:0] u_bi, sum_bi;
	logic signed [ppcm_pkg::SVAL_W-1:0]  dch, dch_c, shi;
	logic [ppcm_pkg::FS_BITS-1:0]  level_cv, level_map, level_calc, lvl_out;
	logic [ppcm_pkg::VAL_W-1:0]    v_cv, wr_data, pv_out;
	logic                          pu_out;

	// output register
	logic                          out_valid_q;
	logic [ppcm_pkg::FS_BITS-1:0]  out_level_q;
	logic [ppcm_pkg::VAL_W-1:0]    out_value_q;
	logic                          out_pu_q;

	// input address and knob check
	always_comb begin
		in_addr = ppcm_pkg::ADDR_W'(in_ch.preset) * ppcm_pkg::ADDR_W'(ppcm_pkg::NUM_KNOBS)
			+ ppcm_pkg::ADDR_W'(in_ch.knob);
		in_knob_ok = (int'(in_ch.knob) < ppcm_pkg::NUM_KNOBS)
			&& (int'(in_ch.preset) < ppcm_pkg::NUM_PRESETS);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ppcm_pkg::S_IDLE: if (in_xfer) state_d = ppcm_pkg::S_READ;
			ppcm_pkg::S_READ: state_d = ppcm_pkg::S_RCP;
			ppcm_pkg::S_RCP:  state_d = ppcm_pkg::S_COR;
			ppcm_pkg::S_COR:  state_d = ppcm_pkg::S_MUL2;
			ppcm_pkg::S_MUL2: state_d = ppcm_pkg::S_MAP2;
			ppcm_pkg::S_MAP2: state_d = ppcm_pkg::S_FIN;
			ppcm_pkg::S_FIN:  if (fin_go) state_d = ppcm_pkg::S_IDLE;
			default:          state_d = ppcm_pkg::S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		out_free  = !out_valid_q || out_ch.ready;
		in_ready  = state_q == ppcm_pkg::S_IDLE;
		in_xfer   = in_ch.valid && in_ready;
		div_start = state_q == ppcm_pkg::S_READ;
		fin_go    = (state_q == ppcm_pkg::S_FIN) && div_rsp.done && out_free;
	end

	assign in_ch.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppcm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_mode_q   <= ppcm_pkg::CV_OFF;
			cv_target_q <= '0;
			cv_depth_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ppcm_pkg::REG_CV_MODE:   cv_mode_q   <= cfg_data[ppcm_pkg::MODE_W-1:0];
				ppcm_pkg::REG_CV_TARGET: cv_target_q <= cfg_data[ppcm_pkg::KNOB_W-1:0];
				ppcm_pkg::REG_CV_DEPTH:  cv_depth_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// item capture on input transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q  <= in_ch.kind;
			knob_q  <= in_ch.knob;
			rd_q    <= in_ch.knob_reading;
			cvr_q   <= in_ch.cv_reading;
			lo_q    <= in_ch.range_low;
			hi_q    <= in_ch.range_high;
			load_q  <= in_ch.load_value;
			addr_q  <= in_addr;
			valid_q <= in_knob_ok;
		end
	end

	// shared terms of the captured item
	always_comb begin
		span      = $signed({1'b0, hi_q}) - $signed({1'b0, lo_q});
		span_mag  = span[ppcm_pkg::VAL_W] ? 8'(-span) : span[ppcm_pkg::VAL_W-1:0];
		num       = $signed({1'b0, ram_rdata}) - $signed({1'b0, lo_q});
		num_neg   = -num;
		num_mag   = num[ppcm_pkg::VAL_W] ? num_neg[ppcm_pkg::VAL_W-1:0]
		                                 : num[ppcm_pkg::VAL_W-1:0];
		depth_sat = (cv_depth_q > ppcm_pkg::DEPTH_CAP) ? ppcm_pkg::DEPTH_CAP : cv_depth_q;
		rcp_c     = ppcm_pkg::RCPP_W'(pct_c_s1) * ppcm_pkg::RCPP_W'(ppcm_pkg::RCP_K);
		rcp_h     = ppcm_pkg::RCPP_W'(pct_h_s1) * ppcm_pkg::RCPP_W'(ppcm_pkg::RCP_K);
		h_full    = ppcm_pkg::pct_fix(est_h_s2, pct_h_s1);
	end

	// memory access: read at transfer, write back at the last step
	always_comb begin
		ram_req.re    = in_xfer;
		ram_req.we    = fin_go && wr_en;
		ram_req.addr  = in_xfer ? in_addr : addr_q;
		ram_req.wdata = wr_data;
	end

	ppcm_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// level divider: |stored - lo| * full scale / |hi - lo|
	always_comb begin
		div_req.start    = div_start;
		div_req.dividend = {num_mag, {ppcm_pkg::FS_BITS{1'b0}}} - ppcm_pkg::PROD_W'(num_mag);
		div_req.divisor  = span_mag;
	end

	ppcm_lvl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// scaling steps
	always_ff @(posedge clk) begin
		unique case (state_q)
			ppcm_pkg::S_READ: begin
				prod_p_s1 <= $signed({1'b0, rd_q}) * span;
				pct_c_s1  <= ppcm_pkg::PCT_W'(cvr_q) * ppcm_pkg::PCT_W'(depth_sat);
				pct_h_s1  <= {depth_sat, {ppcm_pkg::FS_BITS{1'b0}}}
					- ppcm_pkg::PCT_W'(depth_sat);
			end
			ppcm_pkg::S_RCP: begin
				p8_s2    <= ppcm_pkg::to_range(prod_p_s1, lo_q, hi_q);
				est_c_s2 <= rcp_c[ppcm_pkg::RCP_SHIFT +: ppcm_pkg::FS_BITS];
				est_h_s2 <= rcp_h[ppcm_pkg::RCP_SHIFT +: ppcm_pkg::FS_BITS];
			end
			ppcm_pkg::S_COR: begin
				c_s3 <= ppcm_pkg::pct_fix(est_c_s2, pct_c_s1);
				h_s3 <= h_full[ppcm_pkg::FS_BITS-1:1];
			end
			ppcm_pkg::S_MUL2: begin
				prod_c_s4 <= $signed({1'b0, c_s3}) * span;
				prod_h_s4 <= $signed({2'b00, h_s3}) * span;
			end
			ppcm_pkg::S_MAP2: begin
				c8_s5 <= ppcm_pkg::to_range(prod_c_s4, lo_q, hi_q);
				h8_s5 <= ppcm_pkg::to_range(prod_h_s4, lo_q, hi_q);
			end
			default: ;
		endcase
	end

	// cv mixing of level and value
	always_comb begin
		lvl_uni = {1'b0, rd_q} + {1'b0, c_s3};
		u_bi    = $signed({2'b00, c_s3}) - $signed({3'b000, h_s3});
		sum_bi  = $signed({2'b00, rd_q}) + u_bi;
		shi     = $signed({3'b000, hi_q});
		dch     = $signed({3'b000, c8_s5}) - $signed({3'b000, h8_s5});
		if (dch < -shi) begin
			dch_c = -shi;
		end else if (dch > shi) begin
			dch_c = shi;
		end else begin
			dch_c = dch;
		end
		unique case (cv_mode_q)
			ppcm_pkg::CV_UNI: begin
				level_cv = lvl_uni[ppcm_pkg::FS_BITS] ? ppcm_pkg::FS_MAX
					: lvl_uni[ppcm_pkg::FS_BITS-1:0];
				v_cv = ppcm_pkg::clamp_r($signed({3'b000, p8_s2}) + $signed({3'b000, c8_s5}),
					lo_q, hi_q);
			end
			ppcm_pkg::CV_BI: begin
				if (sum_bi < 0) begin
					level_cv = '0;
				end else if (sum_bi > $signed({2'b00, ppcm_pkg::FS_MAX})) begin
					level_cv = ppcm_pkg::FS_MAX;
				end else begin
					level_cv = sum_bi[ppcm_pkg::FS_BITS-1:0];
				end
				v_cv = ppcm_pkg::clamp_r($signed({3'b000, p8_s2}) + dch_c, lo_q, hi_q);
			end
			default: begin
				level_cv = rd_q;
				v_cv     = p8_s2;
			end
		endcase
	end

	// stored value mapped back to full scale
	always_comb begin
		if (num == '0 || num[ppcm_pkg::VAL_W] != span[ppcm_pkg::VAL_W]) begin
			level_map = '0;
		end else if (num_mag > span_mag) begin
			level_map = ppcm_pkg::FS_MAX;
		end else begin
			level_map = div_rsp.quot;
		end
	end

	// pickup decision and result
	always_comb begin
		flag_cur = flags_q[knob_q];
		hit      = p8_s2 == ram_rdata;
		flag_new = flag_cur || hit;
		cv_sel   = (cv_target_q == knob_q) && (cv_depth_q != '0);
		wr_en    = 1'b0;
		wr_data  = load_q;
		level_calc = '0;
		priority if (cv_sel) begin
			level_calc = level_cv;
			wr_data    = v_cv;
		end else if (flag_new) begin
			level_calc = rd_q;
			wr_data    = p8_s2;
		end else if (lo_q != hi_q) begin
			level_calc = level_map;
		end else begin
			// empty range, not picked up
			level_calc = '0;
		end
		if (kind_q == ppcm_pkg::KIND_LOAD) begin
			wr_data = load_q;
		end
		if (valid_q) begin
			wr_en = (kind_q == ppcm_pkg::KIND_LOAD)
				|| ((kind_q == ppcm_pkg::KIND_SAMPLE) && (cv_sel || flag_new));
		end
		lvl_out = (valid_q && kind_q == ppcm_pkg::KIND_SAMPLE) ? level_calc : '0;
		pv_out  = !valid_q ? '0 : (wr_en ? wr_data : ram_rdata);
		if (!valid_q || kind_q == ppcm_pkg::KIND_CLEAR) begin
			pu_out = 1'b0;
		end else if (kind_q == ppcm_pkg::KIND_SAMPLE) begin
			pu_out = flag_new;
		end else begin
			pu_out = flag_cur;
		end
	end

	// pickup flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (fin_go) begin
			if (kind_q == ppcm_pkg::KIND_CLEAR) begin
				flags_q <= '0;
			end else if (valid_q && kind_q == ppcm_pkg::KIND_SAMPLE && hit) begin
				flags_q[knob_q] <= 1'b1;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_level_q <= lvl_out;
			out_value_q <= pv_out;
			out_pu_q    <= pu_out;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.drive_level = out_level_q;
	assign out_ch.param_value = out_value_q;
	assign out_ch.picked_up   = out_pu_q;

	// checks
	`PPCM_ASSERT_NOW(a_ram_single_port, ram_req.we, !ram_req.re, "store read and write collide")
	`PPCM_ASSERT_NEXT(a_accept_starts, in_xfer, state_q == ppcm_pkg::S_READ && !in_ch.ready,
		"accepted item did not start")
	`PPCM_ASSERT_NOW(a_fin_div_done, fin_go, div_rsp.done && !div_rsp.busy,
		"result taken before level divider finished")
	`PPCM_ASSERT_NEXT(a_fin_to_out, fin_go, out_ch.valid, "finished item not presented")
	`PPCM_ASSERT_NEXT(a_clear_flags, fin_go && kind_q == ppcm_pkg::KIND_CLEAR, flags_q == '0,
		"pickup flags not cleared")

endmodule

// ----- sv/ppcm_ram.sv -----
`timescale 1ns / 1ps

module ppcm_ram (
	input  logic                       clk,
	input  ppcm_pkg::ram_req_t         req,
	output logic [ppcm_pkg::VAL_W-1:0] rdata
);

	logic [ppcm_pkg::VAL_W-1:0] mem [ppcm_pkg::STORE_DEPTH];
	logic [ppcm_pkg::VAL_W-1:0] rdata_q;

	// single port, registered read
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/ppcm_lvl_div.sv -----
`timescale 1ns / 1ps

module ppcm_lvl_div (
	input  logic               clk,
	input  logic               arst_n,
	input  ppcm_pkg::div_req_t req,
	output ppcm_pkg::div_rsp_t rsp
);

	logic [ppcm_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           done_q;
	logic [ppcm_pkg::VAL_W-1:0]     rem_q;
	logic [ppcm_pkg::FS_BITS-1:0]   quo_q;
	logic [ppcm_pkg::VAL_W-1:0]     divisor_q;
	logic [ppcm_pkg::VAL_W:0]       trial;
	logic [ppcm_pkg::VAL_W:0]       diff;
	logic                           qbit;
	logic [ppcm_pkg::VAL_W-1:0]     rem_nx;

	// one restoring step per cycle
	always_comb begin
		trial  = {rem_q, quo_q[ppcm_pkg::FS_BITS-1]};
		diff   = trial - {1'b0, divisor_q};
		qbit   = trial >= {1'b0, divisor_q};
		rem_nx = qbit ? diff[ppcm_pkg::VAL_W-1:0] : trial[ppcm_pkg::VAL_W-1:0];
	end

	// step counter and done flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= ppcm_pkg::DIV_CNT_W'(ppcm_pkg::FS_BITS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == ppcm_pkg::DIV_CNT_W'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= req.dividend[ppcm_pkg::PROD_W-1:ppcm_pkg::FS_BITS];
			quo_q     <= req.dividend[ppcm_pkg::FS_BITS-1:0];
			divisor_q <= req.divisor;
		end else if (cnt_q != '0) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[ppcm_pkg::FS_BITS-2:0], qbit};
		end
	end

	assign rsp.busy = cnt_q != '0;
	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

// ----- tb/pot_pickup_cv_mixer_tb.sv -----
`timescale 1ns / 1ps

module pot_pickup_cv_mixer_tb;
	import ppcm_pkg::*;

	// codes the package leaves unnamed
	localparam logic [KIND_W-1:0] KIND_SPARE   = 2'd3;
	localparam logic [KNOB_W-1:0] NO_KNOB      = 2'd3;
	localparam logic [MODE_W-1:0] CV_MODE_RSVD = 2'd3;

	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 200;
	localparam int RX_HOLD     = 400;
	localparam int SETTLE      = 20;
	localparam int QUIET_LIMIT = 4000;
	localparam int GAP_PCT     = 26;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [PRESET_W-1:0] preset;
		logic [KNOB_W-1:0]   knob;
		logic [FS_BITS-1:0]  knob_reading;
		logic [FS_BITS-1:0]  cv_reading;
		logic [VAL_W-1:0]    range_low;
		logic [VAL_W-1:0]    range_high;
		logic [VAL_W-1:0]    load_value;
	} knob_item_t;

	typedef struct packed {
		logic [FS_BITS-1:0] drive_level;
		logic [VAL_W-1:0]   param_value;
		logic               picked_up;
	} mix_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	ppcm_in_if  in_ch ();
	ppcm_out_if out_ch ();

	pot_pickup_cv_mixer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow of the block state and cv registers
	logic [VAL_W-1:0]     store_sh [STORE_DEPTH];
	logic [NUM_KNOBS-1:0] pickup_sh;
	logic [MODE_W-1:0]    cv_mode_sh;
	logic [KNOB_W-1:0]    cv_target_sh;
	logic [DEPTH_W-1:0]   cv_depth_sh;

	knob_item_t           pending_items [$];
	mix_result_t          expected_results [$];
	bit [STORE_DEPTH-1:0] gen_written;

	int   items_queued    = 0;
	int   items_in        = 0;
	int   results_checked = 0;
	int   pickups_seen    = 0;
	int   fail_cnt        = 0;
	int   quiet_cycles    = 0;
	int   hold_left       = 0;
	logic in_took         = 1'b0;
	logic no_gaps         = 1'b0;
	logic rx_hold_req     = 1'b0;
	logic rx_hold_seen    = 1'b0;

	function automatic longint clip(longint x, longint lo, longint hi);
		if (x < lo) begin
			return lo;
		end
		if (x > hi) begin
			return hi;
		end
		return x;
	endfunction

	// linear rescale, division truncates toward zero
	function automatic longint rescale(longint x, longint a, longint b, longint c, longint d);
		return (x - a) * (d - c) / (b - a) + c;
	endfunction

	function automatic longint scale_to_range(longint x, longint lo, longint hi);
		return clip(rescale(x, 0, FULL_SCALE, lo, hi), lo, hi);
	endfunction

	// advance the shadow state by one item and return the result it gives
	function automatic mix_result_t mix_predict(knob_item_t it);
		mix_result_t r;
		int          slot;
		longint      rd, cvr, lo, hi, stored, p8, dpt, c, h, c8, h8, v8, lvl;
		r = '0;
		lvl = 0;
		rd = longint'(it.knob_reading);
		cvr = longint'(it.cv_reading);
		lo = longint'(it.range_low);
		hi = longint'(it.range_high);
		if (it.kind == KIND_CLEAR) begin
			pickup_sh = '0;
		end
		// missing knob: all fields zero, no state change beyond a clear
		if (it.knob >= NUM_KNOBS) begin
			return r;
		end
		slot = int'(it.preset) * NUM_KNOBS + int'(it.knob);
		if (it.kind == KIND_LOAD) begin
			store_sh[slot] = it.load_value;
		end else if (it.kind == KIND_SAMPLE) begin
			stored = longint'(store_sh[slot]);
			p8 = scale_to_range(rd, lo, hi);
			if (p8 == stored) begin
				pickup_sh[it.knob] = 1'b1;
			end
			if (cv_target_sh == it.knob && cv_depth_sh != 0) begin
				// cv knob always writes the mixed value
				dpt = (cv_depth_sh > DEPTH_CAP) ? longint'(MAX_DEPTH) : longint'(cv_depth_sh);
				c = cvr * dpt / MAX_DEPTH;
				h = (longint'(FULL_SCALE) * dpt / MAX_DEPTH) >>> 1;
				c8 = scale_to_range(c, lo, hi);
				h8 = scale_to_range(h, lo, hi);
				v8 = p8;
				lvl = rd;
				if (cv_mode_sh == CV_UNI) begin
					lvl = clip(rd + c, 0, FULL_SCALE);
					v8 = clip(p8 + c8, lo, hi);
				end else if (cv_mode_sh == CV_BI) begin
					lvl = clip(rd + clip(c - h, -FULL_SCALE, FULL_SCALE), 0, FULL_SCALE);
					v8 = clip(p8 + clip(c8 - h8, -hi, hi), lo, hi);
				end
				store_sh[slot] = VAL_W'(v8);
			end else if (pickup_sh[it.knob]) begin
				lvl = rd;
				store_sh[slot] = VAL_W'(p8);
			end else if (lo != hi) begin
				// not picked up: stored value mapped back to full scale
				lvl = clip(rescale(stored, lo, hi, 0, FULL_SCALE), 0, FULL_SCALE);
			end
		end
		r.drive_level = FS_BITS'(lvl);
		r.param_value = store_sh[slot];
		r.picked_up = pickup_sh[it.knob];
		return r;
	endfunction

	// queue one item; an item for a slot that was never loaded is turned into a load
	task automatic offer(input logic [KIND_W-1:0] kind, input logic [PRESET_W-1:0] preset,
			input logic [KNOB_W-1:0] knob, input logic [FS_BITS-1:0] knob_reading,
			input logic [FS_BITS-1:0] cv_reading, input logic [VAL_W-1:0] range_low,
			input logic [VAL_W-1:0] range_high, input logic [VAL_W-1:0] load_value);
		knob_item_t it;
		int         slot;
		slot = int'(preset) * NUM_KNOBS + int'(knob);
		if (knob < NUM_KNOBS && !gen_written[slot] && kind != KIND_LOAD) begin
			kind = KIND_LOAD;
		end
		if (knob < NUM_KNOBS && kind == KIND_LOAD) begin
			gen_written[slot] = 1'b1;
		end
		it.kind = kind;
		it.preset = preset;
		it.knob = knob;
		it.knob_reading = knob_reading;
		it.cv_reading = cv_reading;
		it.range_low = range_low;
		it.range_high = range_high;
		it.load_value = load_value;
		pending_items.push_back(it);
		items_queued++;
	endtask

	// register write, only while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CV_MODE: begin
				cv_mode_sh = val[MODE_W-1:0];
			end
			REG_CV_TARGET: begin
				cv_target_sh = val[KNOB_W-1:0];
			end
			REG_CV_DEPTH: begin
				cv_depth_sh = val;
			end
			default: begin
			end
		endcase
	endtask

	// wait for every queued item to come back
	task automatic wait_drained();
		while (items_in != items_queued || expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE) @(negedge clk);
	endtask

	// input driver
	always @(negedge clk) begin
		knob_item_t next_item;
		if (arst_n && (!in_ch.valid || in_took)) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= (no_gaps ? 0 : GAP_PCT)) begin
				next_item = pending_items.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.kind <= next_item.kind;
				in_ch.preset <= next_item.preset;
				in_ch.knob <= next_item.knob;
				in_ch.knob_reading <= next_item.knob_reading;
				in_ch.cv_reading <= next_item.cv_reading;
				in_ch.range_low <= next_item.range_low;
				in_ch.range_high <= next_item.range_high;
				in_ch.load_value <= next_item.load_value;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// result ready, with a long hold when asked
	always @(negedge clk) begin
		rx_hold_seen <= rx_hold_req;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			out_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (rx_hold_req && !rx_hold_seen) begin
			out_ch.ready <= 1'b0;
			hold_left <= RX_HOLD;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= (no_gaps ? 0 : GAP_PCT));
		end
	end

	// monitor: predict on each input transfer, check each output transfer
	always @(posedge clk) begin
		knob_item_t  taken;
		mix_result_t want;
		if (!arst_n) begin
			in_took <= 1'b0;
		end else begin
			in_took <= in_ch.valid && in_ch.ready;
			if (in_ch.valid && in_ch.ready) begin
				taken.kind = in_ch.kind;
				taken.preset = in_ch.preset;
				taken.knob = in_ch.knob;
				taken.knob_reading = in_ch.knob_reading;
				taken.cv_reading = in_ch.cv_reading;
				taken.range_low = in_ch.range_low;
				taken.range_high = in_ch.range_high;
				taken.load_value = in_ch.load_value;
				expected_results.push_back(mix_predict(taken));
				items_in++;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with no item outstanding");
					fail_cnt++;
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (want.picked_up) begin
						pickups_seen++;
					end
					if (out_ch.drive_level !== want.drive_level) begin
						$error("drive_level mismatch: expected %0d, got %0d",
							want.drive_level, out_ch.drive_level);
						fail_cnt++;
					end
					if (out_ch.param_value !== want.param_value) begin
						$error("param_value mismatch: expected %0d, got %0d",
							want.param_value, out_ch.param_value);
						fail_cnt++;
					end
					if (out_ch.picked_up !== want.picked_up) begin
						$error("picked_up mismatch: expected %0d, got %0d",
							want.picked_up, out_ch.picked_up);
						fail_cnt++;
					end
				end
			end
			// watchdog on cycles without any transfer
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		int                  lo, hi, v, tgt, stp, n, k, rd, stop_at;
		logic [PRESET_W-1:0] pre;
		logic [KNOB_W-1:0]   kb;
		logic [MODE_W-1:0]   m;
		logic [KNOB_W-1:0]   tg;
		logic [DEPTH_W-1:0]  dp;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.kind = '0;
		in_ch.preset = '0;
		in_ch.knob = '0;
		in_ch.knob_reading = '0;
		in_ch.cv_reading = '0;
		in_ch.range_low = '0;
		in_ch.range_high = '0;
		in_ch.load_value = '0;
		out_ch.ready = 1'b0;
		pickup_sh = '0;
		cv_mode_sh = CV_OFF;
		cv_target_sh = '0;
		cv_depth_sh = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part with cv mixing off
		write_reg(REG_CV_MODE, CFG_W'(CV_OFF));
		write_reg(REG_CV_TARGET, CFG_W'(NO_KNOB));
		write_reg(REG_CV_DEPTH, '0);
		offer(KIND_LOAD, 5'd0, 2'd0, 12'd0, 12'd0, 8'd0, 8'd255, 8'd0);
		offer(KIND_LOAD, 5'd31, 2'd2, 12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255);
		offer(KIND_LOAD, 5'd5, 2'd1, 12'd0, 12'd0, 8'd0, 8'd0, 8'd100);
		// far from the stored value, knob not picked up
		offer(KIND_SAMPLE, 5'd0, 2'd0, 12'd4095, 12'd0, 8'd0, 8'd255, 8'd0);
		// pickup at the bottom of the range, then full scale
		offer(KIND_SAMPLE, 5'd0, 2'd0, 12'd0, 12'd4095, 8'd0, 8'd255, 8'd0);
		offer(KIND_SAMPLE, 5'd0, 2'd0, 12'd4095, 12'd0, 8'd0, 8'd255, 8'd0);
		// empty range, not picked up
		offer(KIND_SAMPLE, 5'd31, 2'd2, 12'd1234, 12'd0, 8'd7, 8'd7, 8'd0);
		// reversed ranges
		offer(KIND_SAMPLE, 5'd5, 2'd1, 12'd2000, 12'd0, 8'd200, 8'd50, 8'd0);
		offer(KIND_SAMPLE, 5'd5, 2'd1, 12'd0, 12'd0, 8'd255, 8'd0, 8'd0);
		offer(KIND_SPARE, 5'd5, 2'd1, 12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255);
		// knob that does not exist
		offer(KIND_SAMPLE, 5'd17, NO_KNOB, 12'd4095, 12'd4095, 8'd0, 8'd255, 8'd255);
		offer(KIND_LOAD, 5'd9, NO_KNOB, 12'd0, 12'd0, 8'd0, 8'd0, 8'd77);
		offer(KIND_CLEAR, 5'd3, NO_KNOB, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0);
		// pickup again after the clear
		offer(KIND_SAMPLE, 5'd0, 2'd0, 12'd4095, 12'd0, 8'd0, 8'd255, 8'd0);
		offer(KIND_CLEAR, 5'd31, 2'd2, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0);
		// empty range matching the store picks up
		offer(KIND_SAMPLE, 5'd31, 2'd2, 12'd4095, 12'd4095, 8'd255, 8'd255, 8'd0);
		offer(KIND_SAMPLE, 5'd31, 2'd2, 12'd0, 12'd0, 8'd0, 8'd255, 8'd0);
		offer(KIND_SAMPLE, 5'd5, 2'd1, 12'd2048, 12'd2048, 8'd0, 8'd255, 8'd0);
		offer(KIND_LOAD, 5'd31, 2'd2, 12'd0, 12'd0, 8'd0, 8'd0, 8'd255);
		wait_drained();

		// random phases, one cv setting each
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin m = CV_UNI; tg = 2'd0; dp = 7'd100; end
				1: begin m = CV_BI; tg = 2'd1; dp = 7'd100; end
				2: begin m = CV_BI; tg = 2'd2; dp = 7'd1; end
				3: begin m = CV_OFF; tg = 2'd0; dp = 7'd50; end
				4: begin m = CV_MODE_RSVD; tg = 2'd1; dp = 7'd127; end
				5: begin m = CV_UNI; tg = 2'd2; dp = 7'd37; end
				6: begin m = CV_BI; tg = 2'd0; dp = 7'd127; end
				7: begin m = CV_UNI; tg = NO_KNOB; dp = 7'd100; end
				default: begin
					m = MODE_W'($urandom);
					tg = KNOB_W'($urandom);
					dp = DEPTH_W'($urandom);
				end
			endcase
			write_reg(REG_CV_MODE, {(CFG_W - MODE_W)'($urandom), m});
			write_reg(REG_CV_TARGET, {(CFG_W - KNOB_W)'($urandom), tg});
			write_reg(REG_CV_DEPTH, dp);
			no_gaps <= (p == 3);
			rx_hold_req <= (p == 0 || p == 5);

			stop_at = items_queued + PHASE_ITEMS;
			while (items_queued < stop_at) begin
				if ($urandom_range(9) < 7) begin
					// load a row, then sweep the knob across the stored value
					pre = PRESET_W'($urandom);
					kb = KNOB_W'($urandom_range(NUM_KNOBS - 1));
					case ($urandom_range(9))
						0: begin
							lo = $urandom_range(255);
							hi = lo;
						end
						1: begin
							hi = $urandom_range(254);
							lo = $urandom_range(255, hi + 1);
						end
						default: begin
							lo = $urandom_range(254);
							hi = $urandom_range(255, lo + 1);
						end
					endcase
					if (lo < hi) begin
						v = $urandom_range(hi, lo);
						tgt = ((v - lo) * FULL_SCALE + (hi - lo) - 1) / (hi - lo);
						stp = $urandom_range(FULL_SCALE / (hi - lo), 1);
					end else begin
						v = $urandom_range(1) ? lo : hi;
						tgt = $urandom_range(FULL_SCALE);
						stp = $urandom_range(400, 1);
					end
					if ($urandom_range(3) == 0) begin
						offer(KIND_CLEAR, pre, kb, FS_BITS'($urandom), FS_BITS'($urandom),
							VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
					end
					offer(KIND_LOAD, pre, kb, FS_BITS'($urandom), FS_BITS'($urandom),
						VAL_W'(lo), VAL_W'(hi), VAL_W'(v));
					n = $urandom_range(12, 3);
					k = $urandom_range(n - 1);
					for (int i = 0; i < n; i++) begin
						rd = tgt + (i - k) * stp;
						rd = (rd < 0) ? 0 : ((rd > FULL_SCALE) ? FULL_SCALE : rd);
						offer(KIND_SAMPLE, pre, kb, FS_BITS'(rd), FS_BITS'($urandom),
							VAL_W'(lo), VAL_W'(hi), VAL_W'($urandom));
						if ($urandom_range(11) == 0) begin
							offer(KIND_CLEAR, PRESET_W'($urandom), KNOB_W'($urandom),
								FS_BITS'($urandom), FS_BITS'($urandom),
								VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
						end
					end
				end else begin
					// unstructured items, every field random
					repeat ($urandom_range(4, 1)) begin
						offer(KIND_W'($urandom), PRESET_W'($urandom), KNOB_W'($urandom),
							FS_BITS'($urandom), FS_BITS'($urandom),
							VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
					end
				end
			end
			wait_drained();
			no_gaps <= 1'b0;
			rx_hold_req <= 1'b0;
		end

		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			fail_cnt++;
		end
		$display("checked %0d results of %0d items over %0d cv settings",
			results_checked, items_in, PHASES + 1);
		$display("%0d results had the knob picked up; sweeps, loads, clears and noise mixed",
			pickups_seen);
		if (fail_cnt == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+sv
sv/ppcm_pkg.sv
sv/ppcm_in_if.sv
sv/ppcm_out_if.sv
sv/ppcm_ram.sv
sv/ppcm_lvl_div.sv
sv/pot_pickup_cv_mixer.sv
tb/pot_pickup_cv_mixer_tb.sv
